// ----- hdl/ect_pkg.sv -----
// Shared types, codes and character-class helpers for the expression tokenizer.
// No dependencies; used by every module of the tokenizer and by its checker.
package ect_pkg;

   // Token kind codes
   localparam logic [2:0] KIND_IDENT = 3'd0;
   localparam logic [2:0] KIND_NUM   = 3'd1;
   localparam logic [2:0] KIND_LIT   = 3'd2;
   localparam logic [2:0] KIND_DELIM = 3'd3;
   localparam logic [2:0] KIND_END   = 3'd4;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_NONE  = 8'h00;

   // Most result items one input character can cause
   localparam int unsigned MAX_ITEMS = 3;

   typedef struct packed {
      logic [7:0] ch;
      logic       line_end;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] tok_char;
      logic       has_char;
      logic       tok_last;
      logic       is_float;
   } rsp_type;

   // All result items of one input character, in order
   typedef struct packed {
      logic [1:0]                 cnt;
      rsp_type [MAX_ITEMS-1:0]    item;
   } bundle_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'd9) && (c <= 8'd13));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic is_delim(input logic [7:0] c);
      logic r;
      unique case (c) inside
         "[", "]", "!", "=", "<", ">", ",", ":", "(", ")",
         "+", "-", "*", "/", "&", "|", "~", "%", "^": r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   // Second character of a two-character operator, CH_NONE if c starts none
   function automatic logic [7:0] pair_second(input logic [7:0] c);
      logic [7:0] r;
      unique case (c) inside
         "&", "|", "^", "*":   r = c;
         ":", "!", ">", "<":   r = "=";
         default:              r = CH_NONE;
      endcase
      return r;
   endfunction

   function automatic rsp_type mk_item(input logic [2:0] kind, input logic [7:0] c,
                                       input logic has, input logic last,
                                       input logic flt);
      rsp_type r;
      r.kind     = kind;
      r.tok_char = has ? c : CH_NONE;
      r.has_char = has;
      r.tok_last = last;
      r.is_float = flt;
      return r;
   endfunction

endpackage

// ----- hdl/ect_front.sv -----
// Front end: accepts characters, classifies them and tracks the token in progress.
// Produces at most one bundle of result items per character. Depends on ect_pkg.
module ect_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ect_pkg::req_type    req_data,
   input  logic                q_full,
   output logic                push,
   output ect_pkg::bundle_type push_data
);

   typedef enum logic [4:0] {
      M_IDLE  = 5'b00001,
      M_DELIM = 5'b00010,
      M_NUM   = 5'b00100,
      M_IDENT = 5'b01000,
      M_LIT   = 5'b10000
   } mode_type;

   mode_type   mode_ff, mode_in;
   logic [7:0] held_ff, held_in;
   logic       hv_ff, hv_in;
   logic       flt_ff, flt_in;

   ect_pkg::bundle_type bun;
   logic [1:0] n;
   logic       used;
   logic [7:0] c;
   logic       accept;

   // Closing item of the token in progress, marked last, with the held character if any
   function automatic ect_pkg::rsp_type flush_item(input mode_type m, input logic [7:0] h,
                                                   input logic hv, input logic f);
      ect_pkg::rsp_type r;
      unique case (m)
         M_DELIM: r = ect_pkg::mk_item(ect_pkg::KIND_DELIM, h, 1'b1, 1'b1, 1'b0);
         M_NUM:   r = ect_pkg::mk_item(ect_pkg::KIND_NUM, h, 1'b1, 1'b1, f);
         M_IDENT: r = ect_pkg::mk_item(ect_pkg::KIND_IDENT, h, 1'b1, 1'b1, 1'b0);
         M_LIT:   r = ect_pkg::mk_item(ect_pkg::KIND_LIT, h, hv, 1'b1, 1'b0);
         default: r = '0;
      endcase
      return r;
   endfunction

   assign c         = req_data.ch;
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // Per-character token logic: continue, close, start, then line end
   always_comb begin
      mode_in = mode_ff;
      held_in = held_ff;
      hv_in   = hv_ff;
      flt_in  = flt_ff;
      bun     = '0;
      n       = 2'd0;
      used    = 1'b0;

      unique case (mode_ff)
         M_DELIM: begin
            bun.item[0] = flush_item(mode_ff, held_ff, hv_ff, flt_ff);
            n = 2'd1;
            if (ect_pkg::pair_second(held_ff) == c) begin
               bun.item[0].tok_last = 1'b0;
               bun.item[1] = ect_pkg::mk_item(ect_pkg::KIND_DELIM, c, 1'b1, 1'b1, 1'b0);
               n    = 2'd2;
               used = 1'b1;
            end
            mode_in = M_IDLE;
            hv_in   = 1'b0;
            held_in = ect_pkg::CH_NONE;
            flt_in  = 1'b0;
         end
         M_NUM: begin
            if (ect_pkg::is_digit(c) || (c == ect_pkg::CH_DOT)) begin
               bun.item[0] = ect_pkg::mk_item(ect_pkg::KIND_NUM, held_ff, 1'b1, 1'b0, flt_ff);
               held_in = c;
               if (c == ect_pkg::CH_DOT) flt_in = 1'b1;
               used = 1'b1;
            end else begin
               bun.item[0] = flush_item(mode_ff, held_ff, hv_ff, flt_ff);
               mode_in = M_IDLE;
               hv_in   = 1'b0;
               held_in = ect_pkg::CH_NONE;
               flt_in  = 1'b0;
            end
            n = 2'd1;
         end
         M_IDENT: begin
            if (!ect_pkg::is_delim(c) && !ect_pkg::is_ws(c)) begin
               bun.item[0] = ect_pkg::mk_item(ect_pkg::KIND_IDENT, held_ff, 1'b1, 1'b0, 1'b0);
               held_in = c;
               used = 1'b1;
            end else begin
               bun.item[0] = flush_item(mode_ff, held_ff, hv_ff, flt_ff);
               mode_in = M_IDLE;
               hv_in   = 1'b0;
               held_in = ect_pkg::CH_NONE;
               flt_in  = 1'b0;
            end
            n = 2'd1;
         end
         M_LIT: begin
            if (c == ect_pkg::CH_QUOTE) begin
               bun.item[0] = flush_item(mode_ff, held_ff, hv_ff, flt_ff);
               n = 2'd1;
               mode_in = M_IDLE;
               hv_in   = 1'b0;
               held_in = ect_pkg::CH_NONE;
               flt_in  = 1'b0;
            end else begin
               if (hv_ff) begin
                  bun.item[0] = ect_pkg::mk_item(ect_pkg::KIND_LIT, held_ff, 1'b1, 1'b0, 1'b0);
                  n = 2'd1;
               end
               held_in = c;
               hv_in   = 1'b1;
            end
            used = 1'b1;
         end
         default: mode_in = M_IDLE;
      endcase

      // Start of a new token; a character of no class gives an end item
      if (!used) begin
         if (ect_pkg::is_ws(c)) begin
            // skipped
         end else if (ect_pkg::is_delim(c)) begin
            if (ect_pkg::pair_second(c) != ect_pkg::CH_NONE) begin
               mode_in = M_DELIM;
               held_in = c;
               hv_in   = 1'b1;
            end else begin
               bun.item[n] = ect_pkg::mk_item(ect_pkg::KIND_DELIM, c, 1'b1, 1'b1, 1'b0);
               n = n + 2'd1;
            end
         end else if (c == ect_pkg::CH_QUOTE) begin
            mode_in = M_LIT;
            hv_in   = 1'b0;
            held_in = ect_pkg::CH_NONE;
         end else if (ect_pkg::is_digit(c)) begin
            mode_in = M_NUM;
            held_in = c;
            hv_in   = 1'b1;
            flt_in  = 1'b0;
         end else if (ect_pkg::is_alpha(c)) begin
            mode_in = M_IDENT;
            held_in = c;
            hv_in   = 1'b1;
         end else begin
            bun.item[n] = ect_pkg::mk_item(ect_pkg::KIND_END, ect_pkg::CH_NONE,
                                           1'b0, 1'b1, 1'b0);
            n = n + 2'd1;
         end
      end

      // Line end closes any held token and adds the end marker
      if (req_data.line_end) begin
         if (mode_in != M_IDLE) begin
            bun.item[n] = flush_item(mode_in, held_in, hv_in, flt_in);
            n = n + 2'd1;
         end
         bun.item[n] = ect_pkg::mk_item(ect_pkg::KIND_END, ect_pkg::CH_NONE,
                                        1'b0, 1'b1, 1'b0);
         n = n + 2'd1;
         mode_in = M_IDLE;
         held_in = ect_pkg::CH_NONE;
         hv_in   = 1'b0;
         flt_in  = 1'b0;
      end

      bun.cnt = n;
   end

   assign push      = accept && (n != 2'd0);
   assign push_data = bun;

   // Token state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         held_ff <= ect_pkg::CH_NONE;
         hv_ff   <= 1'b0;
         flt_ff  <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         held_ff <= held_in;
         hv_ff   <= hv_in;
         flt_ff  <= flt_in;
      end
   end

endmodule

// ----- hdl/ect_queue.sv -----
// Short bundle queue between the front end and the output serializer.
// Depends on ect_pkg for the bundle type.
module ect_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ect_pkg::bundle_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output ect_pkg::bundle_type head
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   ect_pkg::bundle_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in;
   logic [AW-1:0] rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == CW'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head      = mem_ff[rd_ff];

   // Pointer wrap and occupancy
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + AW'(1);
      if (pop)  rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + AW'(1);
      if (push && !pop)      cnt_in = cnt_ff + CW'(1);
      else if (pop && !push) cnt_in = cnt_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

endmodule

// ----- hdl/ect_back.sv -----
// Back end: walks the head bundle one item at a time into the output register.
// Depends on ect_pkg.
module ect_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                not_empty,
   input  ect_pkg::bundle_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ect_pkg::rsp_type    rsp_data
);

   logic [1:0]       idx_ff, idx_in;
   logic             vld_ff, vld_in;
   ect_pkg::rsp_type data_ff, data_in;
   logic             load;
   logic             take;

   assign load = !vld_ff || rsp_ready;
   assign take = load && not_empty;
   assign pop  = take && (idx_ff == (head.cnt - 2'd1));

   // Item select and output register refill
   always_comb begin
      idx_in  = idx_ff;
      vld_in  = vld_ff;
      data_in = data_ff;
      if (take) begin
         data_in = head.item[idx_ff];
         vld_in  = 1'b1;
         idx_in  = pop ? 2'd0 : idx_ff + 2'd1;
      end else if (load) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
         vld_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = vld_ff;
   assign rsp_data  = data_ff;

endmodule

// ----- hdl/expression_char_tokenizer.sv -----
// An accepted character's bundle is written into the bundle queue, and the back end then loads
// its results one at a time from the queue head into the output register.
// Throughput: one character per cycle while the bundle queue has room; the output
// register drains one result per cycle while rsp_ready is high, so characters that yield
// two or three results back up into the queue.
// Reset (synchronous): clears token state, queue pointers and the output valid.
module expression_char_tokenizer #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ect_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ect_pkg::rsp_type rsp_data
);

   logic                q_full;
   logic                q_push;
   logic                q_pop;
   logic                q_not_empty;
   ect_pkg::bundle_type q_in;
   ect_pkg::bundle_type q_head;

   // Classify and track tokens
   ect_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .push      (q_push),
      .push_data (q_in)
   );

   // Decoupling queue
   ect_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   // Serialize results
   ect_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (q_not_empty),
      .head      (q_head),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- hdl/ect_checker.sv -----
// Port-level checks for the expression tokenizer, bound to the top level.
// Depends on ect_pkg for the payload types and kind codes.
module ect_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ect_pkg::rsp_type rsp_data
);

   // No result is offered right after reset
   a_reset_quiet: assert property (@(posedge clock) $fell(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Items without a character always close a token
   a_nochar_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.has_char |-> rsp_data.tok_last)
      else $error("empty item not marked last");

   // End items never carry a character
   a_end_nochar: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == ect_pkg::KIND_END) |-> !rsp_data.has_char)
      else $error("end item carries a character");

   // The float flag only appears on number items
   a_float_num: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_float |-> (rsp_data.kind == ect_pkg::KIND_NUM))
      else $error("float flag on a non-number item");

endmodule

bind expression_char_tokenizer ect_checker u_ect_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
